@@ design/dnsd_pkg.sv @@
// Shared constants for the DNS name decompressor: sizes, status codes and byte codes.
`timescale 1ns / 1ps

package dnsd_pkg;

   localparam int MSG_BYTES = 512;
   localparam int MAX_NAME  = 255;
   localparam int ADDR_W    = $clog2(MSG_BYTES);
   localparam int LEN_W     = $clog2(MSG_BYTES + 1);

   typedef logic [2:0] status_type;

   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_PTR_FORBID  = 3'd1;
   localparam status_type ST_PTR_BOUND   = 3'd2;
   localparam status_type ST_LABEL_BOUND = 3'd3;
   localparam status_type ST_TOO_LONG    = 3'd4;
   localparam status_type ST_CUT         = 3'd5;
   localparam status_type ST_HOP_LIMIT   = 3'd6;

   localparam logic [1:0] PTR_TAG   = 2'b11;
   localparam logic [7:0] DOT_CHAR  = 8'h2E;
   localparam logic       ACT_STORE = 1'b0;
   localparam logic       ACT_DECODE = 1'b1;
   localparam logic [7:0] HOPS_RESET = 8'd16;

endpackage

@@ design/dns_name_decompressor.sv @@
// DNS name decompressor: message store, label and pointer walker, packed name output.
//
// Usage. Words on the req_ stream either store one message byte (tuser = 0) or start
// a name decode (tuser = 1). A store word with tlast set makes the message length its
// index plus one. A decode walks the length-prefixed labels from start_offset,
// following compression pointers when allowed, and returns one rsp_ word per eight
// name characters and then a final word (tlast set) carrying the remaining
// characters, the status and, on success, the offset just after the name.
// Handshake. A store gives no result. A decode holds req_tready low until its final
// word is loaded into the output register. The walk is paced by the single read
// port of the message memory, whose registered data the sequencer waits for at
// each length, zero or pointer byte and at each name character.
// Stalls. Results sit in one output register; when the receiver holds rsp_tready low
// the walker stops at the next word it must hand over, and nothing is lost.
// Reset returns the sequencer to idle and clears the message length, the pointer-hop
// limit (to 16) and the output valid flag. The message memory is not cleared; bytes
// must be stored before a decode reads them. The csr_ port takes a new hop limit at
// any time the block is idle.
`timescale 1ns / 1ps

module dns_name_decompressor
   import dnsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // tdata, lowest bit up: byte_index[8:0], byte_value[16:9], start_offset[26:17],
   // allow_compression[27], zero[31:28]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // action
   // tdata, lowest bit up: name_bytes[63:0], byte_count[67:64], status[70:68],
   // next_offset[80:71], zero[87:81]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,
   output logic        rsp_tlast,   // last_result
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // max_pointer_hops
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FETCH   = 3'd1;
   localparam logic [2:0] S_HEAD    = 3'd2;
   localparam logic [2:0] S_PTR     = 3'd3;
   localparam logic [2:0] S_CHAR_RD = 3'd4;
   localparam logic [2:0] S_CHAR_WR = 3'd5;
   localparam logic [2:0] S_DOT     = 3'd6;
   localparam logic [2:0] S_FINAL   = 3'd7;

   logic [ADDR_W-1:0] byte_index;
   logic [7:0]        byte_value;
   logic [9:0]        start_offset;
   logic              allow_compression;

   assign byte_index        = req_tdata[8:0];
   assign byte_value        = req_tdata[16:9];
   assign start_offset      = req_tdata[26:17];
   assign allow_compression = req_tdata[27];

   logic [7:0] mem [MSG_BYTES];
   logic [7:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] msg_len_ff, msg_len_in;
   logic [7:0]       max_hops_ff, max_hops_in;
   logic [9:0]       walk_ff, walk_in;
   logic [9:0]       resume_ff, resume_in;
   logic [7:0]       name_len_ff, name_len_in;
   logic [7:0]       hop_ff, hop_in;
   logic [63:0]      pack_ff, pack_in;
   logic [7:0]       label_rem_ff, label_rem_in;
   logic [5:0]       ptr_hi_ff, ptr_hi_in;
   logic             allow_ff, allow_in;
   logic             compressed_ff, compressed_in;
   status_type       status_ff, status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_word_ff, rsp_word_in;
   logic [3:0]       rsp_count_ff, rsp_count_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [9:0]       rsp_next_ff, rsp_next_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             out_free;
   logic [7:0]       push_byte;
   logic [2:0]       push_pos;
   logic             can_push;
   logic [63:0]      pack_merged;
   logic [10:0]      label_end;
   logic [9:0]       name_sum;
   logic [13:0]      ptr_target;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rd_addr = (state_ff == S_HEAD) ? ADDR_W'(walk_ff + 10'd1) : walk_ff[ADDR_W-1:0];

   // Message memory: one write port for stores, one registered read port for the walker.
   always_ff @(posedge clock) begin
      if (req_accept && req_tuser == ACT_STORE) begin
         mem[byte_index] <= byte_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign push_byte   = (state_ff == S_CHAR_WR) ? rd_data_ff : DOT_CHAR;
   assign push_pos    = name_len_ff[2:0];
   assign can_push    = (push_pos != 3'd7) || out_free;
   assign pack_merged = pack_ff | (64'(push_byte) << {push_pos, 3'b000});
   assign label_end   = 11'(walk_ff) + 11'd1 + 11'(rd_data_ff);
   assign name_sum    = 10'(name_len_ff) + 10'(rd_data_ff) + 10'd2;
   assign ptr_target  = {ptr_hi_ff, rd_data_ff};

   always_comb begin
      state_in      = state_ff;
      msg_len_in    = msg_len_ff;
      max_hops_in   = max_hops_ff;
      walk_in       = walk_ff;
      resume_in     = resume_ff;
      name_len_in   = name_len_ff;
      hop_in        = hop_ff;
      pack_in       = pack_ff;
      label_rem_in  = label_rem_ff;
      ptr_hi_in     = ptr_hi_ff;
      allow_in      = allow_ff;
      compressed_in = compressed_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid) begin
         max_hops_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == ACT_STORE) begin
                  if (req_tlast) begin
                     msg_len_in = LEN_W'(byte_index) + LEN_W'(1);
                  end
               end else begin
                  walk_in       = start_offset;
                  resume_in     = start_offset;
                  allow_in      = allow_compression;
                  compressed_in = 1'b0;
                  name_len_in   = '0;
                  hop_in        = '0;
                  pack_in       = '0;
                  status_in     = ST_OK;
                  state_in      = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (walk_ff >= 10'(msg_len_ff)) begin
               status_in = ST_CUT;
               state_in  = S_FINAL;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            priority if (rd_data_ff == 8'd0) begin
               state_in = S_FINAL;
            end else if (rd_data_ff[7:6] == PTR_TAG) begin
               priority if (!allow_ff) begin
                  status_in = ST_PTR_FORBID;
                  state_in  = S_FINAL;
               end else if (hop_ff >= max_hops_ff) begin
                  status_in = ST_HOP_LIMIT;
                  state_in  = S_FINAL;
               end else begin
                  if (!compressed_ff) begin
                     resume_in = resume_ff + 10'd1;
                  end
                  compressed_in = 1'b1;
                  ptr_hi_in     = rd_data_ff[5:0];
                  if (walk_ff + 10'd1 >= 10'(msg_len_ff)) begin
                     status_in = ST_PTR_BOUND;
                     state_in  = S_FINAL;
                  end else begin
                     state_in = S_PTR;
                  end
               end
            end else begin
               walk_in = walk_ff + 10'd1;
               priority if (label_end > 11'(msg_len_ff)) begin
                  status_in = ST_LABEL_BOUND;
                  state_in  = S_FINAL;
               end else if (name_sum > 10'(MAX_NAME)) begin
                  status_in = ST_TOO_LONG;
                  state_in  = S_FINAL;
               end else begin
                  label_rem_in = rd_data_ff;
                  state_in     = S_CHAR_RD;
               end
            end
         end
         S_PTR: begin
            if (ptr_target >= 14'(msg_len_ff)) begin
               status_in = ST_PTR_BOUND;
               state_in  = S_FINAL;
            end else begin
               walk_in  = 10'(ptr_target);
               hop_in   = hop_ff + 8'd1;
               state_in = S_FETCH;
            end
         end
         S_CHAR_RD: begin
            state_in = (label_rem_ff == 8'd0) ? S_DOT : S_CHAR_WR;
         end
         S_CHAR_WR, S_DOT: begin
            if (can_push) begin
               name_len_in = name_len_ff + 8'd1;
               if (push_pos == 3'd7) begin
                  pack_in       = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_word_in   = pack_merged;
                  rsp_count_in  = 4'd8;
                  rsp_status_in = ST_OK;
                  rsp_next_in   = '0;
                  rsp_last_in   = 1'b0;
               end else begin
                  pack_in = pack_merged;
               end
               if (state_ff == S_CHAR_WR) begin
                  walk_in      = walk_ff + 10'd1;
                  label_rem_in = label_rem_ff - 8'd1;
                  state_in     = S_CHAR_RD;
               end else begin
                  if (!compressed_ff) begin
                     resume_in = walk_ff;
                  end
                  state_in = S_FETCH;
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = pack_ff;
               rsp_count_in  = {1'b0, name_len_ff[2:0]};
               rsp_status_in = status_ff;
               rsp_next_in   = (status_ff == ST_OK) ? resume_ff + 10'd1 : resume_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         msg_len_ff   <= '0;
         max_hops_ff  <= HOPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         msg_len_ff   <= msg_len_in;
         max_hops_ff  <= max_hops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      resume_ff     <= resume_in;
      name_len_ff   <= name_len_in;
      hop_ff        <= hop_in;
      pack_ff       <= pack_in;
      label_rem_ff  <= label_rem_in;
      ptr_hi_ff     <= ptr_hi_in;
      allow_ff      <= allow_in;
      compressed_ff <= compressed_in;
      status_ff     <= status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_next_ff, rsp_status_ff, rsp_count_ff, rsp_word_ff};

   // A word that is not the last of a decode always carries eight characters and no status.
   a_word_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_count_ff == 4'd8 && rsp_status_ff == ST_OK))
      else $error("intermediate result word not full");

   // Character reads stay inside the stored message.
   a_char_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHAR_WR) |-> (walk_ff < 10'(msg_len_ff)))
      else $error("label character read past message end");

   // The name never reaches the length limit.
   a_name_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (10'(name_len_ff) < 10'(MAX_NAME)))
      else $error("name length overran limit");

   // A pointer is only followed while the hop count is under the limit.
   a_hop_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PTR) |-> (hop_ff < max_hops_ff))
      else $error("pointer followed beyond hop limit");

   // An unaccepted result is never overwritten by the walker.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_word_ff) && $stable(rsp_last_ff)))
      else $error("pending result overwritten");

endmodule
